// File: design/matrix_keypad_debounce_scanner_assert.svh
// Assertion macros used by the keypad scanner's scan engine.
`ifndef MATRIX_KEYPAD_DEBOUNCE_SCANNER_ASSERT_SVH
`define MATRIX_KEYPAD_DEBOUNCE_SCANNER_ASSERT_SVH

`ifndef SYNTH
// Condition that must hold at every edge out of reset.
`define KDS_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Condition in one cycle that implies another in the next.
`define KDS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KDS_CHECK(lbl, cond, msg)
`define KDS_CHECK_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/kds_pkg.sv
// Types and constants shared by the keypad scanner modules.
`timescale 1ns / 1ps

package kds_pkg;

  localparam int MAX_ROW_COUNT = 8;
  localparam int MAX_COL_COUNT = 8;
  localparam int KEY_SLOTS     = MAX_ROW_COUNT * MAX_COL_COUNT;

  localparam int ROW_W      = 3;
  localparam int COLS_W     = 8;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 16;
  localparam int CNT_W      = 4;
  localparam int KEY_W      = 6;
  localparam int COL_IDX_W  = $clog2(MAX_COL_COUNT);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int OB_DEPTH   = 2;
  localparam int OB_PTR_W   = $clog2(OB_DEPTH);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] row_count;
    logic [CNT_W-1:0] col_count;
    logic [DEB_W-1:0] debounce_ms;
  } kds_cfg_t;

  // One accepted row sample, already classified for the scan engine
  typedef struct packed {
    logic [KEY_W-1:0]  base;
    logic [CNT_W-1:0]  ncols;
    logic [COLS_W-1:0] closed;
    logic [TIME_W-1:0] now;
  } kds_job_t;

  // Per-key state word
  typedef struct packed {
    logic              raw;
    logic              stable;
    logic [TIME_W-1:0] stamp;
  } kds_entry_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             pressed;
    logic             last_event;
  } kds_event_t;

endpackage

// File: design/kds_in_if.sv
// Row sample channel.
`timescale 1ns / 1ps

interface kds_in_if;
  logic                       valid;
  logic                       ready;
  logic [kds_pkg::ROW_W-1:0]  row_index;
  logic [kds_pkg::COLS_W-1:0] col_closed;
  logic [kds_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output row_index, output col_closed, output now_ms,
                  input ready);
  modport sink   (input valid, input row_index, input col_closed, input now_ms,
                  output ready);
endinterface

// File: design/kds_out_if.sv
// Key event channel.
`timescale 1ns / 1ps

interface kds_out_if;
  logic                      valid;
  logic                      ready;
  logic [kds_pkg::KEY_W-1:0] key_index;
  logic                      pressed;
  logic                      last_event;

  modport source (output valid, output key_index, output pressed, output last_event,
                  input ready);
  modport sink   (input valid, input key_index, input pressed, input last_event,
                  output ready);
endinterface

// File: design/kds_front.sv
// Front end: accepts row samples, drops rows out of range or with no column in use, forms scan jobs.
`timescale 1ns / 1ps

module kds_front (
  kds_in_if.sink           samples,
  input  kds_pkg::kds_cfg_t cfg,
  input  logic              q_full,
  output logic              q_push,
  output kds_pkg::kds_job_t q_job
);

  logic [kds_pkg::CNT_W-1:0]   rows;
  logic [kds_pkg::CNT_W-1:0]   cols;
  logic                        keep;
  logic [kds_pkg::KEY_W+1-1:0] base_full;

  // Clamp the counts to the matrix size
  always_comb begin
    rows = (cfg.row_count > kds_pkg::CNT_W'(kds_pkg::MAX_ROW_COUNT))
           ? kds_pkg::CNT_W'(kds_pkg::MAX_ROW_COUNT) : cfg.row_count;
    cols = (cfg.col_count > kds_pkg::CNT_W'(kds_pkg::MAX_COL_COUNT))
           ? kds_pkg::CNT_W'(kds_pkg::MAX_COL_COUNT) : cfg.col_count;
  end

  // Keep only rows in use when at least one column is in use
  assign keep = ({1'b0, samples.row_index} < rows) && (cols != '0);

  // First key of the row
  assign base_full = (kds_pkg::KEY_W+1)'(samples.row_index) * (kds_pkg::KEY_W+1)'(cols);

  assign samples.ready = !q_full;
  assign q_push        = samples.valid && !q_full && keep;

  always_comb begin
    q_job.base   = base_full[kds_pkg::KEY_W-1:0];
    q_job.ncols  = cols;
    q_job.closed = samples.col_closed;
    q_job.now    = samples.now_ms;
  end

endmodule

// File: design/kds_queue.sv
// Short job queue between the front end and the scan engine.
`timescale 1ns / 1ps

module kds_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kds_pkg::kds_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output kds_pkg::kds_job_t head
);

  kds_pkg::kds_job_t               jobs [kds_pkg::Q_DEPTH];
  logic [kds_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [kds_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [kds_pkg::Q_PTR_W:0]       count;

  assign full       = (count == (kds_pkg::Q_PTR_W+1)'(kds_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = jobs[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push) begin
      jobs[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/kds_back.sv
// Scan engine: walks the columns of each job through the per-key state memory
// and emits press and release beats.
`timescale 1ns / 1ps
`include "matrix_keypad_debounce_scanner_assert.svh"

module kds_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [kds_pkg::DEB_W-1:0]   debounce_ms,
  input  logic                        q_valid,
  input  kds_pkg::kds_job_t           q_head,
  output logic                        q_pop,
  output logic                        ev_valid,
  output kds_pkg::kds_event_t         ev,
  input  logic                        ev_ready
);

  // Column walker
  logic [kds_pkg::COL_IDX_W-1:0] col;
  logic                          last_col;
  logic [kds_pkg::KEY_W-1:0]     issue_key;
  logic                          issue;

  // Lookup stage
  logic                          s1_v;
  logic                          s1_go;
  logic                          s1_ready;
  logic [kds_pkg::KEY_W-1:0]     s1_key;
  logic                          s1_level;
  logic [kds_pkg::TIME_W-1:0]    s1_now;
  logic                          s1_end;

  // State memory
  kds_pkg::kds_entry_t           mem [kds_pkg::KEY_SLOTS];
  logic [kds_pkg::KEY_SLOTS-1:0] vld;
  kds_pkg::kds_entry_t           rd_mem;
  logic                          rd_vld;
  logic                          fwd_hit;
  kds_pkg::kds_entry_t           fwd_data;
  kds_pkg::kds_entry_t           entry;
  kds_pkg::kds_entry_t           wdata;
  logic                          we;

  // Debounce decision
  logic [kds_pkg::TIME_W-1:0]    new_stamp;
  logic [kds_pkg::TIME_W-1:0]    elapsed;
  logic                          fire;

  // Held event, waiting to learn whether it is the last of its job
  logic                          hv;
  logic                          hv_next;
  logic                          hdone;
  logic                          hdone_next;
  logic                          hload;
  logic [kds_pkg::KEY_W-1:0]     hkey;
  logic                          hlvl;

  // Output buffer
  kds_pkg::kds_event_t           ob [kds_pkg::OB_DEPTH];
  logic [kds_pkg::OB_PTR_W-1:0]  ob_wr;
  logic [kds_pkg::OB_PTR_W-1:0]  ob_rd;
  logic [kds_pkg::OB_PTR_W:0]    ob_count;
  logic                          ob_space;
  logic                          ob_pop;
  logic                          push;
  kds_pkg::kds_event_t           push_ev;

  assign ob_space = (ob_count != (kds_pkg::OB_PTR_W+1)'(kds_pkg::OB_DEPTH));
  assign ob_pop   = ev_valid && ev_ready;

  // Stage handshakes: a held final event blocks the lookup stage until flushed
  assign s1_go    = s1_v && !hdone && ob_space;
  assign s1_ready = !s1_v || s1_go;
  assign issue    = q_valid && s1_ready;

  assign last_col  = (kds_pkg::CNT_W'(col) == (q_head.ncols - 1'b1));
  assign issue_key = q_head.base + kds_pkg::KEY_W'(col);
  assign q_pop     = issue && last_col;

  // Step through the columns of the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (issue) begin
      col <= last_col ? '0 : col + 1'b1;
    end
  end

  // Lookup stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_ready) begin
      s1_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_key   <= issue_key;
      s1_level <= q_head.closed[col];
      s1_now   <= q_head.now;
      s1_end   <= last_col;
    end
  end

  // State memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[s1_key] <= wdata;
    end
    if (issue) begin
      rd_mem <= mem[issue_key];
    end
  end

  // Entry valid bits stand for the all-zero reset state
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[s1_key] <= 1'b1;
    end
  end

  // Forward a write that lands in the same cycle as the read of that key
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_vld   <= vld[issue_key];
      fwd_hit  <= we && (s1_key == issue_key);
      fwd_data <= wdata;
    end
  end

  assign entry = fwd_hit ? fwd_data : (rd_vld ? rd_mem : '0);

  // Restart the timer on a raw change, accept a level that has settled
  always_comb begin
    new_stamp = (s1_level != entry.raw) ? s1_now : entry.stamp;
    elapsed   = s1_now - new_stamp;
    fire      = (elapsed > kds_pkg::TIME_W'(debounce_ms)) && (s1_level != entry.stable);
  end

  assign we = s1_go;

  always_comb begin
    wdata.raw    = s1_level;
    wdata.stable = fire ? s1_level : entry.stable;
    wdata.stamp  = new_stamp;
  end

  // Decide which beat, if any, goes to the output buffer
  always_comb begin
    push               = 1'b0;
    push_ev.key_index  = hkey;
    push_ev.pressed    = hlvl;
    push_ev.last_event = 1'b1;
    hv_next            = hv;
    hdone_next         = hdone;
    hload              = 1'b0;
    if (hv && hdone && ob_space) begin
      push       = 1'b1;
      hv_next    = 1'b0;
      hdone_next = 1'b0;
    end else if (s1_go) begin
      if (fire) begin
        if (hv) begin
          push               = 1'b1;
          push_ev.last_event = 1'b0;
        end
        hload      = 1'b1;
        hv_next    = 1'b1;
        hdone_next = s1_end;
      end else if (s1_end && hv) begin
        push    = 1'b1;
        hv_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv    <= 1'b0;
      hdone <= 1'b0;
    end else begin
      hv    <= hv_next;
      hdone <= hdone_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hload) begin
      hkey <= s1_key;
      hlvl <= s1_level;
    end
  end

  // Output buffer storage
  always_ff @(posedge clk) begin
    if (push) begin
      ob[ob_wr] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr    <= '0;
      ob_rd    <= '0;
      ob_count <= '0;
    end else begin
      if (push) begin
        ob_wr <= ob_wr + 1'b1;
      end
      if (ob_pop) begin
        ob_rd <= ob_rd + 1'b1;
      end
      unique case ({push, ob_pop})
        2'b10:   ob_count <= ob_count + 1'b1;
        2'b01:   ob_count <= ob_count - 1'b1;
        default: ob_count <= ob_count;
      endcase
    end
  end

  assign ev_valid = (ob_count != '0);
  assign ev       = ob[ob_rd];

  `KDS_CHECK(a_done_needs_held, !hdone || hv, "final marker without a held event")
  `KDS_CHECK(a_ob_bound, ob_count <= (kds_pkg::OB_PTR_W+1)'(kds_pkg::OB_DEPTH), "output buffer overrun")
  `KDS_CHECK_NEXT(a_s1_holds, s1_v && !s1_go, s1_v && $stable(s1_key), "stalled lookup lost its key")
  `KDS_CHECK_NEXT(a_final_flush, hv && hdone && ob_space, !hv, "final event not flushed")

endmodule

// File: design/matrix_keypad_debounce_scanner.sv
// Matrix keypad scanner with per-key debounce: configuration registers and top level.
//
// Each accepted row sample is checked against the row and column counts and,
// when in use, queued; the scan engine then walks its columns in use (one to
// eight) through the per-key state memory, which takes at most one read and
// one write a cycle, and stalls to flush an event raised by the last column
// of a sample; samples for rows not in use are not scanned. Samples are taken
// while earlier ones are still scanned, through a four-deep job queue; events
// leave through a two-beat output buffer, at most one a cycle.
// All per-key state reads as zero after reset without a clearing pass.
`timescale 1ns / 1ps

module matrix_keypad_debounce_scanner (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [kds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kds_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  kds_in_if.sink                           samples,
  kds_out_if.source                        events
);

  kds_pkg::kds_cfg_t   cfg;
  logic                q_push;
  kds_pkg::kds_job_t   q_job;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  kds_pkg::kds_job_t   q_head;
  kds_pkg::kds_event_t ev;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_count   <= kds_pkg::CNT_W'(8);
      cfg.col_count   <= kds_pkg::CNT_W'(8);
      cfg.debounce_ms <= kds_pkg::DEB_W'(50);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        kds_pkg::REG_ROW_COUNT:   cfg.row_count   <= cfg_wdata[kds_pkg::CNT_W-1:0];
        kds_pkg::REG_COL_COUNT:   cfg.col_count   <= cfg_wdata[kds_pkg::CNT_W-1:0];
        kds_pkg::REG_DEBOUNCE_MS: cfg.debounce_ms <= cfg_wdata[kds_pkg::DEB_W-1:0];
        default: ;
      endcase
    end
  end

  kds_front u_front (
    .samples (samples),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_job)
  );

  kds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  kds_back u_back (
    .clk         (clk),
    .rst         (rst),
    .debounce_ms (cfg.debounce_ms),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .ev_valid    (events.valid),
    .ev          (ev),
    .ev_ready    (events.ready)
  );

  assign events.key_index  = ev.key_index;
  assign events.pressed    = ev.pressed;
  assign events.last_event = ev.last_event;

endmodule

// File: bench/tb_matrix_keypad_debounce_scanner.sv
// Self-checking bench for the keypad debounce scanner: directed plan, then random row samples.
`timescale 1ns / 1ps

module tb_matrix_keypad_debounce_scanner;
  import kds_pkg::*;

  localparam int     NUM_PHASES   = 8;
  localparam int     PHASE_ITEMS  = 60;
  localparam int     DRAIN_TAIL   = 64;
  localparam int     SETTLE_BOUND = 20000;
  localparam int     PRINT_CAP    = 40;
  localparam longint LIMIT_NS     = 15_000_000;

  typedef enum logic {DO_SAMPLE, DO_WRITE} plan_kind_e;
  // How the expectation of a sample is formed
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_e;

  typedef struct {
    plan_kind_e            kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    logic [ROW_W-1:0]      row;
    logic [COLS_W-1:0]     closed;
    logic [TIME_W-1:0]     now;
    check_e                chk;
    logic [KEY_W-1:0]      key;
    logic                  press;
  } plan_step_t;

  logic clk;
  logic rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kds_in_if  sample_ch ();
  kds_out_if event_ch ();

  matrix_keypad_debounce_scanner u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .samples   (sample_ch),
    .events    (event_ch)
  );

  // Shadow of the registers and of the per-key debounce state
  logic [CNT_W-1:0]  cfg_rows;
  logic [CNT_W-1:0]  cfg_cols;
  logic [DEB_W-1:0]  cfg_debounce;
  logic              key_raw    [KEY_SLOTS];
  logic              key_stable [KEY_SLOTS];
  logic [TIME_W-1:0] key_stamp  [KEY_SLOTS];

  kds_event_t pending_key_events[$];
  int         mismatch_count;
  int         beat_count;
  int         hold_off_request;
  bit         src_idle_on;
  bit         sink_stalls_on;
  logic [COLS_W-1:0] row_pattern [MAX_ROW_COUNT];
  logic [TIME_W-1:0] clock_ms;

  plan_step_t directed_plan [34] = '{
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd0, 8'h00, 32'd0, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd0, 8'h01, 32'd100, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd0, 8'h01, 32'd150, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd0, 8'h01, 32'd151, CHK_ONE, 6'd0, 1'b1},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd7, 8'hFF, 32'd1000, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd7, 8'hFF, 32'd1051, CHK_MODEL, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd7, 8'h00, 32'd2000, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd7, 8'h00, 32'd2051, CHK_MODEL, 6'd0, 1'b0},
    // timer across the 32-bit wrap
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd3, 8'h80, 32'hFFFF_FFF0, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd3, 8'h80, 32'h0000_0030, CHK_ONE, 6'd31, 1'b1},
    // contact bounce restarts the timer
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd1, 8'h0F, 32'd3000, CHK_MODEL, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd1, 8'h05, 32'd3040, CHK_MODEL, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd1, 8'h05, 32'd3080, CHK_MODEL, 6'd0, 1'b0},
    // row out of range
    '{DO_WRITE, REG_ROW_COUNT, 16'hFFF2, 3'd0, 8'h00, 32'd0, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd5, 8'hFF, 32'd4000, CHK_NONE, 6'd0, 1'b0},
    // fewer columns: renumbered keys, high bits ignored
    '{DO_WRITE, REG_COL_COUNT, 16'h0003, 3'd0, 8'h00, 32'd0, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd1, 8'h07, 32'd5000, CHK_MODEL, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd1, 8'hFF, 32'd5100, CHK_MODEL, 6'd0, 1'b0},
    // zero debounce accepts after one millisecond
    '{DO_WRITE, REG_DEBOUNCE_MS, 16'h0000, 3'd0, 8'h00, 32'd0, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd0, 8'h06, 32'd6000, CHK_MODEL, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd0, 8'h06, 32'd6001, CHK_MODEL, 6'd0, 1'b0},
    // longest debounce
    '{DO_WRITE, REG_DEBOUNCE_MS, 16'hFFFF, 3'd0, 8'h00, 32'd0, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd0, 8'h01, 32'd7000, CHK_MODEL, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd0, 8'h01, 32'd72535, CHK_MODEL, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd0, 8'h01, 32'd72536, CHK_MODEL, 6'd0, 1'b0},
    // zero counts scan nothing
    '{DO_WRITE, REG_ROW_COUNT, 16'h0000, 3'd0, 8'h00, 32'd0, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd0, 8'hFF, 32'd80000, CHK_NONE, 6'd0, 1'b0},
    '{DO_WRITE, REG_ROW_COUNT, 16'h000F, 3'd0, 8'h00, 32'd0, CHK_NONE, 6'd0, 1'b0},
    '{DO_WRITE, REG_COL_COUNT, 16'h0000, 3'd0, 8'h00, 32'd0, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd7, 8'hFF, 32'd90000, CHK_NONE, 6'd0, 1'b0},
    // oversized counts clamp to the maximum
    '{DO_WRITE, REG_COL_COUNT, 16'hABCF, 3'd0, 8'h00, 32'd0, CHK_NONE, 6'd0, 1'b0},
    '{DO_WRITE, REG_DEBOUNCE_MS, 16'd50, 3'd0, 8'h00, 32'd0, CHK_NONE, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd7, 8'h55, 32'hFFFF_FFFF, CHK_MODEL, 6'd0, 1'b0},
    '{DO_SAMPLE, REG_ROW_COUNT, 16'h0000, 3'd7, 8'h55, 32'h0000_0040, CHK_MODEL, 6'd0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned eff_count(input logic [CNT_W-1:0] v, input int unsigned limit);
    return (v > limit) ? limit : v;
  endfunction

  // Debounce one row sample against the shadow state; return the events it raises
  function automatic void predict_key_events(input logic [ROW_W-1:0] row,
                                             input logic [COLS_W-1:0] closed,
                                             input logic [TIME_W-1:0] now,
                                             ref kds_event_t evs[$]);
    int unsigned       rows_eff;
    int unsigned       cols_eff;
    int unsigned       key;
    logic              lvl;
    logic [TIME_W-1:0] elapsed;
    kds_event_t        ev;
    evs.delete();
    rows_eff = eff_count(cfg_rows, MAX_ROW_COUNT);
    cols_eff = eff_count(cfg_cols, MAX_COL_COUNT);
    if (row >= rows_eff) return;
    for (int c = 0; c < cols_eff; c++) begin
      key = row * cols_eff + c;
      lvl = closed[c];
      if (lvl != key_raw[key]) key_stamp[key] = now;
      elapsed = now - key_stamp[key];
      if (elapsed > {16'd0, cfg_debounce} && lvl != key_stable[key]) begin
        key_stable[key] = lvl;
        ev.key_index  = KEY_W'(key);
        ev.pressed    = lvl;
        ev.last_event = 1'b0;
        evs.push_back(ev);
      end
      key_raw[key] = lvl;
    end
    if (evs.size() > 0) evs[evs.size()-1].last_event = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("ERROR t=%0t beat %0d: %s got %0d expected %0d", $realtime, beat_count, what,
               got, want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ROW_COUNT:   cfg_rows = data[CNT_W-1:0];
      REG_COL_COUNT:   cfg_cols = data[CNT_W-1:0];
      REG_DEBOUNCE_MS: cfg_debounce = data[DEB_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected event, then let the pipeline run dry
  task automatic settle_events(input int tail);
    int waited;
    waited = 0;
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_key_events.size() != 0 && waited < SETTLE_BOUND) begin
      @(posedge clk);
      waited++;
    end
    repeat (tail) @(posedge clk);
  endtask

  // Offer one row sample after a random gap; predict once it is taken
  task automatic send_sample(input logic [ROW_W-1:0] row, input logic [COLS_W-1:0] closed,
                             input logic [TIME_W-1:0] now, input check_e chk,
                             input logic [KEY_W-1:0] key, input logic press);
    int         gap;
    int         roll;
    kds_event_t predicted[$];
    kds_event_t ev;
    gap = 0;
    if (src_idle_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 90) gap = $urandom_range(5, 30);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.row_index  <= row;
    sample_ch.col_closed <= closed;
    sample_ch.now_ms     <= now;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predict_key_events(row, closed, now, predicted);
    case (chk)
      CHK_MODEL: begin
        foreach (predicted[i]) pending_key_events.push_back(predicted[i]);
      end
      CHK_ONE: begin
        ev.key_index  = key;
        ev.pressed    = press;
        ev.last_event = 1'b1;
        pending_key_events.push_back(ev);
      end
      default: ;
    endcase
  endtask

  // Mostly held patterns with random content, some bounce and some noise
  task automatic send_random_sample(output bit in_use);
    int                roll;
    int unsigned       rows_eff;
    int unsigned       cols_eff;
    logic [ROW_W-1:0]  row;
    logic [COLS_W-1:0] closed;
    logic [TIME_W-1:0] step;
    rows_eff = eff_count(cfg_rows, MAX_ROW_COUNT);
    cols_eff = eff_count(cfg_cols, MAX_COL_COUNT);
    roll = $urandom_range(0, 99);
    if (rows_eff > 0 && roll < 85) row = ROW_W'($urandom_range(0, rows_eff - 1));
    else row = ROW_W'($urandom_range(0, 7));
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      closed = row_pattern[row];
    end else if (roll < 80) begin
      row_pattern[row] = COLS_W'($urandom);
      closed = row_pattern[row];
    end else if (roll < 95) begin
      closed = row_pattern[row] ^ (8'h01 << $urandom_range(0, 7));
    end else begin
      closed = COLS_W'($urandom);
    end
    roll = $urandom_range(0, 99);
    if (roll < 45) step = $urandom_range(0, cfg_debounce / 2 + 1);
    else if (roll < 95) step = cfg_debounce + $urandom_range(1, cfg_debounce / 4 + 3);
    else step = $urandom;
    clock_ms = clock_ms + step;
    in_use = (row < rows_eff) && (cols_eff > 0);
    send_sample(row, closed, clock_ms, CHK_MODEL, '0, 1'b0);
  endtask

  // Event receiver: check each beat, then choose the next ready
  initial begin : event_sink
    int         stall_left;
    int         roll;
    kds_event_t want;
    stall_left = 0;
    event_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && event_ch.valid && event_ch.ready) begin
        beat_count++;
        if (pending_key_events.size() == 0) begin
          report_mismatch("unexpected event, key", event_ch.key_index, -1);
        end else begin
          want = pending_key_events.pop_front();
          if (event_ch.key_index !== want.key_index)
            report_mismatch("key_index", event_ch.key_index, want.key_index);
          if (event_ch.pressed !== want.pressed)
            report_mismatch("pressed", event_ch.pressed, want.pressed);
          if (event_ch.last_event !== want.last_event)
            report_mismatch("last_event", event_ch.last_event, want.last_event);
        end
      end
      if (hold_off_request > 0) begin
        stall_left = hold_off_request;
        hold_off_request = 0;
      end
      roll = $urandom_range(0, 99);
      if (stall_left > 0) begin
        event_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_stalls_on && roll < 25) begin
        stall_left = (roll < 22) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        event_ch.ready <= 1'b0;
      end else begin
        event_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int          roll;
    int          counted;
    bit          in_use;
    logic [3:0]  rows_val;
    logic [3:0]  cols_val;
    logic [15:0] deb_val;

    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_index            <= '0;
    cfg_wdata            <= '0;
    sample_ch.valid      <= 1'b0;
    sample_ch.row_index  <= '0;
    sample_ch.col_closed <= '0;
    sample_ch.now_ms     <= '0;
    mismatch_count   = 0;
    beat_count       = 0;
    hold_off_request = 0;
    src_idle_on      = 1'b1;
    sink_stalls_on   = 1'b1;
    cfg_rows         = 4'd8;
    cfg_cols         = 4'd8;
    cfg_debounce     = 16'd50;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      key_raw[k]    = 1'b0;
      key_stable[k] = 1'b0;
      key_stamp[k]  = '0;
    end
    for (int r = 0; r < MAX_ROW_COUNT; r++) row_pattern[r] = COLS_W'($urandom);
    clock_ms = $urandom;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan: reset values first, then each register and corner in turn
    for (int i = 0; i < $size(directed_plan); i++) begin
      if (directed_plan[i].kind == DO_WRITE) begin
        settle_events(DRAIN_TAIL);
        write_reg(directed_plan[i].reg_idx, directed_plan[i].wdata);
      end else begin
        send_sample(directed_plan[i].row, directed_plan[i].closed, directed_plan[i].now,
                    directed_plan[i].chk, directed_plan[i].key, directed_plan[i].press);
      end
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_events(DRAIN_TAIL);
      src_idle_on    = (ph % 3) != 0;
      sink_stalls_on = (ph % 4) != 1;
      roll = $urandom_range(0, 99);
      rows_val = (roll < 80) ? 4'($urandom_range(1, 8)) :
                 (roll < 90) ? 4'd0 : 4'($urandom_range(9, 15));
      roll = $urandom_range(0, 99);
      cols_val = (roll < 80) ? 4'($urandom_range(1, 8)) :
                 (roll < 90) ? 4'd0 : 4'($urandom_range(9, 15));
      roll = $urandom_range(0, 99);
      if (roll < 40) deb_val = 16'($urandom_range(0, 5));
      else if (roll < 80) deb_val = 16'($urandom_range(6, 60));
      else if (roll < 95) deb_val = 16'($urandom_range(61, 2000));
      else deb_val = 16'hFFFF;
      // phases carrying the back-pressure tests need a live keypad
      if (ph == 2) begin
        rows_val = 4'd8;
        cols_val = 4'd8;
        deb_val  = 16'($urandom_range(0, 10));
      end else if (ph == 5) begin
        rows_val = 4'($urandom_range(1, 8));
        cols_val = 4'($urandom_range(1, 8));
      end
      write_reg(REG_ROW_COUNT, {12'($urandom), rows_val});
      write_reg(REG_COL_COUNT, {12'($urandom), cols_val});
      write_reg(REG_DEBOUNCE_MS, deb_val);

      if (eff_count(cfg_rows, MAX_ROW_COUNT) == 0 || eff_count(cfg_cols, MAX_COL_COUNT) == 0) begin
        repeat (8) send_random_sample(in_use);
      end else begin
        counted = 0;
        while (counted < PHASE_ITEMS) begin
          // hold the receiver off while samples keep coming
          if (ph == 2 && counted == 10) hold_off_request = 300;
          // pause the sender until every event is out
          if (ph == 5 && counted == 30) settle_events(0);
          send_random_sample(in_use);
          if (in_use) counted++;
        end
      end
    end

    settle_events(DRAIN_TAIL);
    if (pending_key_events.size() != 0)
      report_mismatch("events never delivered", 0, pending_key_events.size());
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
